[hdl/qri_pkg.sv]
package qri_pkg;

    // Fraction bits of every fixed-point value in the block.
    localparam int FRAC_BITS  = 16;
    localparam int NUM_COEFS  = 10;
    localparam int COEF_IDX_W = 4;

    // Pipeline depths of the arithmetic units.
    localparam int FMUL_LAT  = 4;
    localparam int ROOT_W    = (64 + FRAC_BITS) / 2;
    localparam int DIV_STEPS = 32;

    // Command queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_RAY  = 1'b1
    } cmd_t;

    typedef logic signed [63:0] fix64_t;

    localparam fix64_t FIX_MAX = {1'b0, {63{1'b1}}};
    localparam fix64_t FIX_MIN = {1'b1, {63{1'b0}}};

    // Distance reported on a miss: -1.0.
    localparam logic [31:0] MISS_DIST = 32'(-(64'sd1 <<< FRAC_BITS));
    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic        is_ray;
        logic [3:0]  idx;
        logic [31:0] value;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } qitem_t;

    function automatic fix64_t sat_add(fix64_t a, fix64_t b);
        fix64_t s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return a[63] ? FIX_MIN : FIX_MAX;
        end
        return s;
    endfunction

    function automatic fix64_t sat_sub(fix64_t a, fix64_t b);
        fix64_t s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) begin
            return a[63] ? FIX_MIN : FIX_MAX;
        end
        return s;
    endfunction

    function automatic logic [63:0] mag64(fix64_t a);
        logic [63:0] u;
        u = a;
        return a[63] ? (~u + 64'd1) : u;
    endfunction

    // Negation that saturates the most negative value.
    function automatic fix64_t sat_neg(fix64_t a);
        logic [63:0] u;
        u = a;
        return (a == FIX_MIN) ? FIX_MAX : fix64_t'(~u + 64'd1);
    endfunction

endpackage

[hdl/qri_cmd_if.sv]
interface qri_cmd_if import qri_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;

    modport source (
        output valid, command, coef_index, coef_value, dir_x, dir_y, dir_z,
        input  ready
    );
    modport sink (
        input  valid, command, coef_index, coef_value, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

[hdl/qri_res_if.sv]
interface qri_res_if import qri_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic               degenerate;
    logic signed [31:0] distance;

    modport source (
        output valid, hit, degenerate, distance,
        input  ready
    );
    modport sink (
        input  valid, hit, degenerate, distance,
        output ready
    );
endinterface

[hdl/quadric_ray_intersect_core.sv]
// Ray / quadric intersection core.
// The cmd channel carries command words. A load word (command 0) writes one
// of the ten Q16.16 surface coefficients a..j, picked by coef_index, and
// gives no result; an index above 9 is dropped. A ray word (command 1)
// carries a direction from the origin and gives exactly one result word on
// the result channel: hit, degenerate and the Q16.16 distance to the root
// that adds the square root, saturated to 32 bits, or -1.0 on a miss or a
// zero quadratic term. Words are executed in arrival order, so a ray sees
// every load before it. A word is taken whenever valid and ready are high;
// one ray per cycle is sustained unless a result waits on result.ready. A
// ray's path runs through the multipliers, one square-root stage per result
// bit and a 32-step divider. When a result waits and the receiver holds off
// ready, the whole back pipeline freezes and a four-entry queue keeps taking
// words until it fills; then cmd.ready drops. Reset empties the queue,
// clears the pipeline's valid flags and sets all coefficients to zero.
module quadric_ray_intersect_core import qri_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    qri_cmd_if.sink   cmd,
    qri_res_if.source result
);

    logic   pop;
    logic   head_valid;
    qitem_t head;

    qri_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    qri_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .result     (result)
    );

endmodule

[hdl/qri_fmul.sv]
// Signed fixed-point multiply: exact 128-bit product from four 32x32
// partial products, shifted right by FRAC_BITS and saturated to 64 bits.
module qri_fmul import qri_pkg::*; (
    input  logic   clk,
    input  logic   en,
    input  fix64_t a,
    input  fix64_t b,
    output fix64_t p
);

    logic [63:0]  ma_reg;
    logic [63:0]  mb_reg;
    logic         n1_reg;
    logic [63:0]  pp00_reg;
    logic [63:0]  pp01_reg;
    logic [63:0]  pp10_reg;
    logic [63:0]  pp11_reg;
    logic         n2_reg;
    logic [127:0] prod_reg;
    logic [127:0] prod_next;
    logic         n3_reg;
    fix64_t       p_reg;
    fix64_t       p_next;
    logic [64:0]  mid;
    logic [127:0] sh;

    always_comb
    begin
        mid       = {1'b0, pp01_reg} + {1'b0, pp10_reg};
        prod_next = {pp11_reg, pp00_reg} + {31'd0, mid, 32'd0};
        sh        = prod_reg >> FRAC_BITS;
        if (|sh[127:63])
        begin
            p_next = n3_reg ? FIX_MIN : FIX_MAX;
        end
        else
        begin
            p_next = n3_reg ? fix64_t'(~sh[63:0] + 64'd1) : fix64_t'(sh[63:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg   <= mag64(a);
            mb_reg   <= mag64(b);
            n1_reg   <= a[63] ^ b[63];
            pp00_reg <= ma_reg[31:0] * mb_reg[31:0];
            pp01_reg <= ma_reg[31:0] * mb_reg[63:32];
            pp10_reg <= ma_reg[63:32] * mb_reg[31:0];
            pp11_reg <= ma_reg[63:32] * mb_reg[63:32];
            n2_reg   <= n1_reg;
            prod_reg <= prod_next;
            n3_reg   <= n2_reg;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

[hdl/qri_sqrt.sv]
// Pipelined integer square root: floor(sqrt(rad * 2^FRAC_BITS)),
// one result bit per stage.
module qri_sqrt import qri_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  logic [63:0]       rad,
    output logic [ROOT_W-1:0] root
);

    localparam int V_W = 2 * ROOT_W;
    localparam int RW  = ROOT_W + 2;

    logic [RW-1:0]     rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [V_W-1:0]    v_reg     [ROOT_W];
    logic [RW-1:0]     p_rem     [ROOT_W];
    logic [ROOT_W-1:0] p_root    [ROOT_W];
    logic [V_W-1:0]    p_v       [ROOT_W];
    logic [RW-1:0]     r2        [ROOT_W];
    logic [RW-1:0]     trial     [ROOT_W];
    logic              ge        [ROOT_W];
    logic [RW-1:0]     rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];

    always_comb
    begin
        p_rem[0]  = '0;
        p_root[0] = '0;
        p_v[0]    = V_W'({rad, {FRAC_BITS{1'b0}}});
        for (int k = 1; k < ROOT_W; k++)
        begin
            p_rem[k]  = rem_reg[k-1];
            p_root[k] = root_reg[k-1];
            p_v[k]    = v_reg[k-1];
        end
        for (int k = 0; k < ROOT_W; k++)
        begin
            r2[k]        = {p_rem[k][RW-3:0], p_v[k][V_W-1 -: 2]};
            trial[k]     = {p_root[k], 2'b01};
            ge[k]        = r2[k] >= trial[k];
            rem_next[k]  = ge[k] ? (r2[k] - trial[k]) : r2[k];
            root_next[k] = {p_root[k][ROOT_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                v_reg[k]    <= p_v[k] << 2;
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

[hdl/qri_div.sv]
// Pipelined restoring divider for the low 32 quotient bits. The caller
// supplies a starting remainder already below the divisor.
module qri_div import qri_pkg::*; (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] rem_in,
    input  logic [31:0] lo_in,
    input  logic [63:0] dv_in,
    output logic [31:0] q
);

    logic [63:0] rem_reg  [DIV_STEPS];
    logic [31:0] lo_reg   [DIV_STEPS];
    logic [63:0] dv_reg   [DIV_STEPS];
    logic [31:0] q_reg    [DIV_STEPS];
    logic [63:0] p_rem    [DIV_STEPS];
    logic [31:0] p_lo     [DIV_STEPS];
    logic [63:0] p_dv     [DIV_STEPS];
    logic [31:0] p_q      [DIV_STEPS];
    logic [64:0] r2       [DIV_STEPS];
    logic        ge       [DIV_STEPS];
    logic [64:0] diff     [DIV_STEPS];
    logic [63:0] rem_next [DIV_STEPS];

    always_comb
    begin
        p_rem[0] = rem_in;
        p_lo[0]  = lo_in;
        p_dv[0]  = dv_in;
        p_q[0]   = '0;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            p_rem[k] = rem_reg[k-1];
            p_lo[k]  = lo_reg[k-1];
            p_dv[k]  = dv_reg[k-1];
            p_q[k]   = q_reg[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            r2[k]       = {p_rem[k], p_lo[k][31]};
            ge[k]       = r2[k] >= {1'b0, p_dv[k]};
            diff[k]     = r2[k] - {1'b0, p_dv[k]};
            rem_next[k] = ge[k] ? diff[k][63:0] : r2[k][63:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                lo_reg[k]  <= p_lo[k] << 1;
                dv_reg[k]  <= p_dv[k];
                q_reg[k]   <= {p_q[k][30:0], ge[k]};
            end
        end
    end

    assign q = q_reg[DIV_STEPS-1];

endmodule

[hdl/qri_front.sv]
// Accepts command words, drops loads to nonexistent coefficients and
// queues the rest in order for the back end.
module qri_front import qri_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    qri_cmd_if.sink    cmd,
    input  logic       pop,
    output logic       head_valid,
    output qitem_t     head
);

    qitem_t             q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic [Q_CNT_W-1:0] cnt_next;
    logic               accept;
    logic               keep;
    qitem_t             item;

    assign cmd.ready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        item.is_ray = (cmd.command == CMD_RAY);
        item.idx    = cmd.coef_index;
        item.value  = cmd.coef_value;
        item.x      = cmd.dir_x;
        item.y      = cmd.dir_y;
        item.z      = cmd.dir_z;
        keep        = accept && (item.is_ray ||
                      (cmd.coef_index < COEF_IDX_W'(NUM_COEFS)));
        cnt_next    = cnt_reg + Q_CNT_W'(keep) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (keep)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("command queue count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> cnt_reg != '0)
        else $error("pop from empty command queue");
    assert property (@(posedge clk) disable iff (!rst_n) !cmd.ready |-> head_valid)
        else $error("queue reports full while empty");

endmodule

[hdl/qri_back.sv]
// Executes queued words in order: loads update the coefficient file,
// rays run through one stall-together pipeline.
module qri_back import qri_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  qitem_t    head,
    output logic      pop,
    qri_res_if.source result
);

    localparam int S_A     = FMUL_LAT;
    localparam int S_B     = S_A + FMUL_LAT;
    localparam int S_BETA  = S_A + 2;
    localparam int S_ALPHA = S_B + 5;
    localparam int S_C     = S_ALPHA + FMUL_LAT;
    localparam int S_D     = S_C + 3;
    localparam int S_R     = S_D + ROOT_W;
    localparam int S_Q     = S_R + 3 + DIV_STEPS;
    localparam int S_OUT   = S_Q + 1;
    localparam int BD_N    = S_ALPHA - S_BETA;
    localparam int AD_N    = S_D - S_ALPHA;

    typedef struct packed {
        fix64_t alpha;
        fix64_t nbeta;
        logic   miss;
        logic   deg;
    } side_t;

    typedef struct packed {
        logic miss;
        logic deg;
        logic neg;
        logic ovf;
    } flags_t;

    logic        en;
    logic        vld_reg [S_OUT+1];
    logic [31:0] coef_reg [NUM_COEFS];

    // Stage 0 operands.
    fix64_t x0_reg, y0_reg, z0_reg;
    fix64_t c0_reg [NUM_COEFS];

    fix64_t fa_a [9];
    fix64_t fa_b [9];
    fix64_t fa_p [9];
    fix64_t cd_reg [FMUL_LAT][6];
    fix64_t g_reg [S_ALPHA];
    fix64_t fb_p [6];
    fix64_t t1_reg, iz_reg, beta_reg;
    fix64_t bd_reg [BD_N];
    fix64_t acc_reg [5];
    fix64_t trm_reg [5][6];
    fix64_t bb_p, ag_p;
    fix64_t ad_reg [AD_N];
    fix64_t bd2_reg [AD_N];
    fix64_t ag2_reg, ag4_reg, bb1_reg, bb2_reg, d_reg;
    side_t  side_reg [ROOT_W];
    side_t  side_next;
    logic [63:0]       rad;
    logic [ROOT_W-1:0] root;
    fix64_t      num_reg, den_reg;
    logic [1:0]  fl1_reg;
    logic        neg2_reg;
    logic [63:0] nmag_reg, dmag_reg;
    logic [1:0]  fl2_reg;
    logic [63:0] hi_reg, dv_reg, hi_next;
    logic [31:0] lo_reg;
    flags_t      f3_reg;
    flags_t      fq_reg [DIV_STEPS];
    logic [31:0] q;
    logic        hit_reg, deg_reg;
    logic [31:0] dist_reg, dist_next;
    logic        hit_next;
    flags_t      ff;

    assign en     = !vld_reg[S_OUT] || result.ready;
    assign pop    = en && head_valid;

    // Coefficient file, cleared at reset and written in queue order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COEFS; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (pop && !head.is_ray)
        begin
            coef_reg[head.idx] <= head.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= S_OUT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= pop && head.is_ray;
            for (int k = 1; k <= S_OUT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // First-level products: squares, cross terms and linear terms.
    always_comb
    begin
        fa_a[0] = x0_reg;     fa_b[0] = x0_reg;
        fa_a[1] = y0_reg;     fa_b[1] = y0_reg;
        fa_a[2] = z0_reg;     fa_b[2] = z0_reg;
        fa_a[3] = x0_reg;     fa_b[3] = y0_reg;
        fa_a[4] = x0_reg;     fa_b[4] = z0_reg;
        fa_a[5] = y0_reg;     fa_b[5] = z0_reg;
        fa_a[6] = c0_reg[6];  fa_b[6] = x0_reg;
        fa_a[7] = c0_reg[7];  fa_b[7] = y0_reg;
        fa_a[8] = c0_reg[8];  fa_b[8] = z0_reg;
    end

    for (genvar k = 0; k < 9; k++)
    begin : g_fa
        qri_fmul u_fmul (
            .clk (clk),
            .en  (en),
            .a   (fa_a[k]),
            .b   (fa_b[k]),
            .p   (fa_p[k])
        );
    end

    // Second-order coefficients times the squares and cross terms.
    for (genvar k = 0; k < 6; k++)
    begin : g_fb
        qri_fmul u_fmul (
            .clk (clk),
            .en  (en),
            .a   (cd_reg[FMUL_LAT-1][k]),
            .b   (fa_p[k]),
            .p   (fb_p[k])
        );
    end

    qri_fmul u_fmul_bb (
        .clk (clk),
        .en  (en),
        .a   (bd_reg[BD_N-1]),
        .b   (bd_reg[BD_N-1]),
        .p   (bb_p)
    );

    qri_fmul u_fmul_ag (
        .clk (clk),
        .en  (en),
        .a   (acc_reg[4]),
        .b   (g_reg[S_ALPHA-1]),
        .p   (ag_p)
    );

    assign rad = d_reg[63] ? 64'd0 : 64'(d_reg);

    qri_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (rad),
        .root (root)
    );

    qri_div u_div (
        .clk    (clk),
        .en     (en),
        .rem_in (hi_reg),
        .lo_in  (lo_reg),
        .dv_in  (dv_reg),
        .q      (q)
    );

    always_comb
    begin
        side_next.alpha = ad_reg[AD_N-1];
        side_next.nbeta = sat_neg(bd2_reg[AD_N-1]);
        side_next.deg   = (ad_reg[AD_N-1] == '0);
        side_next.miss  = d_reg[63] || side_next.deg;

        hi_next = nmag_reg >> (32 - FRAC_BITS);

        ff = fq_reg[DIV_STEPS-1];
        if (ff.miss)
        begin
            hit_next  = 1'b0;
            dist_next = MISS_DIST;
        end
        else if (ff.ovf || q > (ff.neg ? NEG_LIMIT : POS_LIMIT))
        begin
            hit_next  = 1'b1;
            dist_next = ff.neg ? NEG_LIMIT : POS_LIMIT;
        end
        else
        begin
            hit_next  = 1'b1;
            dist_next = ff.neg ? (~q + 32'd1) : q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= {{32{head.x[31]}}, head.x};
            y0_reg <= {{32{head.y[31]}}, head.y};
            z0_reg <= {{32{head.z[31]}}, head.z};
            for (int k = 0; k < NUM_COEFS; k++)
            begin
                c0_reg[k] <= {{32{coef_reg[k][31]}}, coef_reg[k]};
            end

            for (int k = 0; k < 6; k++)
            begin
                cd_reg[0][k] <= c0_reg[k];
            end
            for (int j = 1; j < FMUL_LAT; j++)
            begin
                cd_reg[j] <= cd_reg[j-1];
            end

            g_reg[0] <= c0_reg[9];
            for (int j = 1; j < S_ALPHA; j++)
            begin
                g_reg[j] <= g_reg[j-1];
            end

            // Linear term.
            t1_reg   <= sat_add(fa_p[6], fa_p[7]);
            iz_reg   <= fa_p[8];
            beta_reg <= sat_add(t1_reg, iz_reg);
            bd_reg[0] <= beta_reg;
            for (int j = 1; j < BD_N; j++)
            begin
                bd_reg[j] <= bd_reg[j-1];
            end

            // Quadratic term, accumulated one term per stage after the first two.
            acc_reg[0] <= sat_add(fb_p[0], fb_p[1]);
            trm_reg[0] <= fb_p;
            for (int j = 1; j < 5; j++)
            begin
                acc_reg[j] <= sat_add(acc_reg[j-1], trm_reg[j-1][j+1]);
                trm_reg[j] <= trm_reg[j-1];
            end

            ad_reg[0]  <= acc_reg[4];
            bd2_reg[0] <= bd_reg[BD_N-1];
            for (int j = 1; j < AD_N; j++)
            begin
                ad_reg[j]  <= ad_reg[j-1];
                bd2_reg[j] <= bd2_reg[j-1];
            end

            // Discriminant: beta^2 - 4 * alpha * gamma.
            ag2_reg <= sat_add(ag_p, ag_p);
            bb1_reg <= bb_p;
            ag4_reg <= sat_add(ag2_reg, ag2_reg);
            bb2_reg <= bb1_reg;
            d_reg   <= sat_sub(bb2_reg, ag4_reg);

            side_reg[0] <= side_next;
            for (int j = 1; j < ROOT_W; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end

            num_reg <= sat_add(side_reg[ROOT_W-1].nbeta,
                               fix64_t'({{(64-ROOT_W){1'b0}}, root}));
            den_reg <= sat_add(side_reg[ROOT_W-1].alpha, side_reg[ROOT_W-1].alpha);
            fl1_reg <= {side_reg[ROOT_W-1].miss, side_reg[ROOT_W-1].deg};

            neg2_reg <= num_reg[63] ^ den_reg[63];
            nmag_reg <= mag64(num_reg);
            dmag_reg <= mag64(den_reg);
            fl2_reg  <= fl1_reg;

            // A quotient of 2^32 or more saturates on a hit, so only its
            // low 32 bits go through the divider.
            hi_reg      <= hi_next;
            lo_reg      <= 32'(nmag_reg << FRAC_BITS);
            dv_reg      <= dmag_reg;
            f3_reg.miss <= fl2_reg[1];
            f3_reg.deg  <= fl2_reg[0];
            f3_reg.neg  <= neg2_reg;
            f3_reg.ovf  <= hi_next >= dmag_reg;

            fq_reg[0] <= f3_reg;
            for (int j = 1; j < DIV_STEPS; j++)
            begin
                fq_reg[j] <= fq_reg[j-1];
            end

            hit_reg  <= hit_next;
            deg_reg  <= ff.deg;
            dist_reg <= dist_next;
        end
    end

    assign result.valid      = vld_reg[S_OUT];
    assign result.hit        = hit_reg;
    assign result.degenerate = deg_reg;
    assign result.distance   = dist_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.degenerate |-> !result.hit)
        else $error("degenerate ray reported as hit");
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.hit |-> result.distance == MISS_DIST)
        else $error("miss without the miss distance");
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && $past(en) |-> $past(head_valid && head.is_ray))
        else $error("ray entered the pipeline without a queued ray");

endmodule
